[hw/rtl/breakpoint_envelope_evaluator_core_macros.svh]
// Assertion macros shared by the envelope evaluator RTL.
// IMP checks a consequent in the same cycle, NXT checks it in the following cycle.
`ifndef BREAKPOINT_ENVELOPE_EVALUATOR_CORE_MACROS_SVH
`define BREAKPOINT_ENVELOPE_EVALUATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BEE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("breakpoint envelope check failed");
`define BEE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("breakpoint envelope check failed");
`else
`define BEE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BEE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/bee_pkg.sv]
package bee_pkg;

	// field widths of the stream words
	localparam int IDX_W      = 6;
	localparam int TIME_W     = 48;
	localparam int VALUE_W    = 16;
	localparam int SHAPE_W    = 3;
	localparam int COUNT_W    = 7;
	localparam int FRAC_W     = 16;
	localparam int DIV_CNT_W  = 4;
	localparam int MUL_W      = 17;
	localparam int PROD_W     = 34;
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// input tdata layout, lowest field first
	localparam int IDX_LSB   = 0;
	localparam int TIME_LSB  = IDX_LSB + IDX_W;
	localparam int VALUE_LSB = TIME_LSB + TIME_W;
	localparam int SHAPE_LSB = VALUE_LSB + VALUE_W;
	localparam int POS_LSB   = SHAPE_LSB + SHAPE_W;

	// Q1.15 unity and Q1.16 one
	localparam logic [VALUE_W-1:0] UNITY    = 16'd32768;
	localparam logic [MUL_W-1:0]   FRAC_ONE = 17'd65536;

	// item kinds carried in tuser
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_EVAL  = 1'b1;

	// segment shapes; the remaining codes interpolate linearly
	localparam logic [SHAPE_W-1:0] SHAPE_STEP     = 3'd0;
	localparam logic [SHAPE_W-1:0] SHAPE_LINEAR   = 3'd1;
	localparam logic [SHAPE_W-1:0] SHAPE_EASE_IN  = 3'd2;
	localparam logic [SHAPE_W-1:0] SHAPE_EASE_OUT = 3'd3;
	localparam logic [SHAPE_W-1:0] SHAPE_S_CURVE  = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_DEFAULT = 2'd1;

	// status of the shared subtractor
	typedef struct packed {
		logic borrow;
		logic zero;
	} sub_flags_t;

endpackage

[hw/rtl/bee_table.sv]
// Breakpoint storage: one write port, one registered read port.
module bee_table #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int TW    = 48
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [AW-1:0]                    wr_addr,
	input  logic [TW-1:0]                    wr_time,
	input  logic [bee_pkg::VALUE_W-1:0]      wr_value,
	input  logic [bee_pkg::SHAPE_W-1:0]      wr_shape,
	input  logic [AW-1:0]                    rd_addr,
	output logic [TW-1:0]                    rd_time,
	output logic [bee_pkg::VALUE_W-1:0]      rd_value,
	output logic [bee_pkg::SHAPE_W-1:0]      rd_shape
);

	localparam int VW = bee_pkg::VALUE_W;
	localparam int SW = bee_pkg::SHAPE_W;
	localparam int EW = TW + VW + SW;

	logic [EW-1:0] mem_q [DEPTH];
	logic [EW-1:0] rd_word_q;

	// entry = {time, value, shape}
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_time, wr_value, wr_shape};
		end
		rd_word_q <= mem_q[rd_addr];
	end

	assign rd_shape = rd_word_q[SW-1:0];
	assign rd_value = rd_word_q[SW +: VW];
	assign rd_time  = rd_word_q[SW+VW +: TW];

endmodule

[hw/rtl/bee_alu.sv]
// Shared arithmetic: one subtractor with borrow/zero status, one 17x17 multiplier.
module bee_alu #(
	parameter int SUB_W = 49
) (
	input  logic [SUB_W-1:0]              sub_a,
	input  logic [SUB_W-1:0]              sub_b,
	output logic [SUB_W-1:0]              sub_diff,
	output bee_pkg::sub_flags_t           sub_flags,
	input  logic [bee_pkg::MUL_W-1:0]     mul_a,
	input  logic [bee_pkg::MUL_W-1:0]     mul_b,
	output logic [bee_pkg::PROD_W-1:0]    mul_prod
);

	localparam int PW = bee_pkg::PROD_W;

	logic [SUB_W:0] wide_diff;

	// extra top bit is the borrow
	assign wide_diff        = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_diff         = wide_diff[SUB_W-1:0];
	assign sub_flags.borrow = wide_diff[SUB_W];
	assign sub_flags.zero   = (wide_diff[SUB_W-1:0] == '0);

	assign mul_prod = PW'(mul_a) * PW'(mul_b);

endmodule

[hw/rtl/breakpoint_envelope_evaluator_core.sv]
// Breakpoint envelope evaluator.
// Input stream (s_axis_*): tuser selects the word kind. A write word stores one
// breakpoint (slot, time, Q1.15 value, shape) and returns nothing. An evaluate
// word returns one Q1.15 curve value on the output stream (m_axis_*).
// Config channel (cfg_*): index 0 = point count, index 1 = empty-table default.
// Always ready; write it only while no evaluation is in flight.
// A write word is stored while idle, and the core stays ready for the next word.
// An evaluate word walks the first N stored points, one memory read per cycle,
// then for an interpolated segment runs a 16-step restoring divide and 5 steps
// of shaping and blending on the shared subtractor and multiplier (linear
// shapes skip the square).
// Held or default values skip the divide, and an empty table skips the scan.
// One word is worked on at a time; s_axis_tready is low while busy.
// The result sits in an output register; a stalled receiver holds it there and
// the core accepts the next word, but a later result waits until it is taken.
// Reset clears the count to 0 and the default to unity; the table itself is
// not cleared and slots must be written before they are counted.
`include "breakpoint_envelope_evaluator_core_macros.svh"

module breakpoint_envelope_evaluator_core #(
	parameter int MAX_POINTS = 64,
	parameter int TIME_BITS  = 48
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bee_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bee_pkg::CFG_DATA_W-1:0]       cfg_data,
	// input stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// tdata: point_index, point_time, point_value, point_shape, position, zero pad
	input  logic [bee_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	// tuser: mode
	input  logic                                 s_axis_tuser,
	// output stream
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// tdata: curve_value
	output logic [bee_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

	localparam int AW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_MAX = (MAX_POINTS < 127) ? MAX_POINTS : 127;
	localparam int CNT_W   = $clog2(CNT_MAX + 1);
	localparam int TK      = (TIME_BITS < bee_pkg::TIME_W) ? TIME_BITS : bee_pkg::TIME_W;
	localparam int SUBW    = TIME_BITS + 1;
	localparam int VW      = bee_pkg::VALUE_W;
	localparam int SHW     = bee_pkg::SHAPE_W;
	localparam int MW      = bee_pkg::MUL_W;
	localparam int PW      = bee_pkg::PROD_W;
	localparam int FW      = bee_pkg::FRAC_W;
	localparam int DCW     = bee_pkg::DIV_CNT_W;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_SCAN = 11'b000_0000_0010,
		ST_NUM  = 11'b000_0000_0100,
		ST_DEN  = 11'b000_0000_1000,
		ST_DIV  = 11'b000_0001_0000,
		ST_SQ   = 11'b000_0010_0000,
		ST_SHP  = 11'b000_0100_0000,
		ST_M1   = 11'b000_1000_0000,
		ST_M2   = 11'b001_0000_0000,
		ST_FIN  = 11'b010_0000_0000,
		ST_OUT  = 11'b100_0000_0000
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [VW-1:0]          dflt_q;
	logic [CNT_W-1:0]       rd_idx_q;
	logic                   cmp_vld_q;
	logic                   have_b_q, have_a_q, b_eq_q, a_eq_q;
	logic [TIME_BITS-1:0]   t1_q, t2_q, pos_q, r_q, den_q;
	logic [VW-1:0]          v1_q, v2_q, res_q, m_data_q;
	logic [SHW-1:0]         sh1_q;
	logic [FW-1:0]          q_q;
	logic [DCW-1:0]         div_cnt_q;
	logic [PW-1:0]          prod_q, acc_q;
	logic [MW-1:0]          s_q;
	logic                   m_tvalid_q;

	// input word fields
	logic [bee_pkg::IDX_W-1:0]   in_idx;
	logic [TIME_BITS-1:0]        in_time, in_pos;
	logic [VW-1:0]               in_value_raw, in_value;
	logic [SHW-1:0]              in_shape;
	logic                        in_acc, wr_acc, eval_acc;

	assign in_idx       = s_axis_tdata[bee_pkg::IDX_LSB +: bee_pkg::IDX_W];
	assign in_time      = TIME_BITS'(s_axis_tdata[bee_pkg::TIME_LSB +: TK]);
	assign in_pos       = TIME_BITS'(s_axis_tdata[bee_pkg::POS_LSB +: TK]);
	assign in_value_raw = s_axis_tdata[bee_pkg::VALUE_LSB +: VW];
	assign in_value     = (in_value_raw > bee_pkg::UNITY) ? bee_pkg::UNITY : in_value_raw;
	assign in_shape     = s_axis_tdata[bee_pkg::SHAPE_LSB +: SHW];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign wr_acc        = in_acc && (s_axis_tuser == bee_pkg::MODE_WRITE);
	assign eval_acc      = in_acc && (s_axis_tuser == bee_pkg::MODE_EVAL);

	// breakpoint table
	logic                 tbl_wr_en;
	logic [AW-1:0]        tbl_rd_addr;
	logic [TIME_BITS-1:0] rd_time;
	logic [VW-1:0]        rd_value;
	logic [SHW-1:0]       rd_shape;

	assign tbl_wr_en   = wr_acc && (int'(in_idx) < MAX_POINTS);
	assign tbl_rd_addr = AW'(rd_idx_q);

	bee_table #(
		.DEPTH (MAX_POINTS),
		.AW    (AW),
		.TW    (TIME_BITS)
	) u_table (
		.clk      (clk),
		.wr_en    (tbl_wr_en),
		.wr_addr  (AW'(in_idx)),
		.wr_time  (in_time),
		.wr_value (in_value),
		.wr_shape (in_shape),
		.rd_addr  (tbl_rd_addr),
		.rd_time  (rd_time),
		.rd_value (rd_value),
		.rd_shape (rd_shape)
	);

	// shared subtractor / multiplier operand select
	logic [SUBW-1:0]     sub_a, sub_b, sub_diff;
	bee_pkg::sub_flags_t sub_flags;
	logic [MW-1:0]       mul_a, mul_b, t_ext, u_ext, sq_op, s_nx;
	logic [PW-1:0]       mul_prod, rnd16, rnd15, blend_sum;

	assign t_ext = {1'b0, q_q};
	assign u_ext = bee_pkg::FRAC_ONE - t_ext;

	// square operand by shape: t, or 1 - t for the falling halves
	always_comb begin
		case (sh1_q)
			bee_pkg::SHAPE_EASE_OUT: sq_op = u_ext;
			bee_pkg::SHAPE_S_CURVE:  sq_op = q_q[FW-1] ? u_ext : t_ext;
			default:                 sq_op = t_ext;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_NUM: begin
				sub_a = {1'b0, pos_q};
				sub_b = {1'b0, t1_q};
			end
			ST_DEN: begin
				sub_a = {1'b0, t2_q};
				sub_b = {1'b0, t1_q};
			end
			ST_DIV: begin
				sub_a = {r_q, 1'b0};
				sub_b = {1'b0, den_q};
			end
			default: begin
				sub_a = {1'b0, rd_time};
				sub_b = {1'b0, pos_q};
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_SQ: begin
				mul_a = sq_op;
				mul_b = sq_op;
			end
			ST_M1: begin
				mul_a = MW'(v1_q);
				mul_b = bee_pkg::FRAC_ONE - s_q;
			end
			default: begin
				mul_a = MW'(v2_q);
				mul_b = s_q;
			end
		endcase
	end

	bee_alu #(
		.SUB_W (SUBW)
	) u_alu (
		.sub_a     (sub_a),
		.sub_b     (sub_b),
		.sub_diff  (sub_diff),
		.sub_flags (sub_flags),
		.mul_a     (mul_a),
		.mul_b     (mul_b),
		.mul_prod  (mul_prod)
	);

	// shaped fraction from the registered square
	assign rnd16 = (prod_q + PW'(32768)) >> 16;
	assign rnd15 = (prod_q + PW'(16384)) >> 15;

	always_comb begin
		case (sh1_q)
			bee_pkg::SHAPE_EASE_IN:  s_nx = MW'(rnd16);
			bee_pkg::SHAPE_EASE_OUT: s_nx = bee_pkg::FRAC_ONE - MW'(rnd16);
			bee_pkg::SHAPE_S_CURVE:  s_nx = q_q[FW-1] ? (bee_pkg::FRAC_ONE - MW'(rnd15))
			                                          : MW'(rnd15);
			default:                 s_nx = t_ext;
		endcase
	end

	assign blend_sum = acc_q + prod_q + PW'(32768);

	// scan status
	logic rd_en, scan_done, cmp_le, cmp_ge, interp, needs_sq, out_free, div_last;

	assign rd_en     = (rd_idx_q < cnt_q);
	assign scan_done = !rd_en && !cmp_vld_q;
	assign cmp_le    = sub_flags.borrow || sub_flags.zero;
	assign cmp_ge    = !sub_flags.borrow;
	assign interp    = have_b_q && have_a_q && !b_eq_q && !a_eq_q &&
	                   (sh1_q != bee_pkg::SHAPE_STEP);
	assign needs_sq  = (sh1_q == bee_pkg::SHAPE_EASE_IN) ||
	                   (sh1_q == bee_pkg::SHAPE_EASE_OUT) ||
	                   (sh1_q == bee_pkg::SHAPE_S_CURVE);
	assign out_free  = !m_tvalid_q || m_axis_tready;
	assign div_last  = (div_cnt_q == DCW'(FW - 1));

	// config registers
	logic [bee_pkg::COUNT_W-1:0] cfg_cnt_raw;
	logic [VW-1:0]               cfg_dflt_raw;

	assign cfg_ready    = 1'b1;
	assign cfg_cnt_raw  = cfg_data[bee_pkg::COUNT_W-1:0];
	assign cfg_dflt_raw = cfg_data[VW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			dflt_q <= bee_pkg::UNITY;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bee_pkg::REG_POINT_COUNT: begin
					cnt_q <= (int'(cfg_cnt_raw) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
					                                          : CNT_W'(cfg_cnt_raw);
				end
				bee_pkg::REG_EMPTY_DEFAULT: begin
					dflt_q <= (cfg_dflt_raw > bee_pkg::UNITY) ? bee_pkg::UNITY : cfg_dflt_raw;
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmp_vld_q  <= 1'b0;
			have_b_q   <= 1'b0;
			have_a_q   <= 1'b0;
			b_eq_q     <= 1'b0;
			a_eq_q     <= 1'b0;
			rd_idx_q   <= '0;
			div_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// output word valid: set from ST_OUT, cleared once taken
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (eval_acc) begin
						rd_idx_q  <= '0;
						cmp_vld_q <= 1'b0;
						have_b_q  <= 1'b0;
						have_a_q  <= 1'b0;
						b_eq_q    <= 1'b0;
						a_eq_q    <= 1'b0;
						state_q   <= (cnt_q == '0) ? ST_OUT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_vld_q <= rd_en;
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (cmp_vld_q) begin
						if (cmp_le) begin
							have_b_q <= 1'b1;
							b_eq_q   <= sub_flags.zero;
						end
						if (cmp_ge && !have_a_q) begin
							have_a_q <= 1'b1;
							a_eq_q   <= sub_flags.zero;
						end
					end
					if (scan_done) begin
						state_q <= interp ? ST_NUM : ST_OUT;
					end
				end
				ST_NUM: state_q <= ST_DEN;
				ST_DEN: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_last) begin
						state_q <= needs_sq ? ST_SQ : ST_SHP;
					end
				end
				ST_SQ:  state_q <= ST_SHP;
				ST_SHP: state_q <= ST_M1;
				ST_M1:  state_q <= ST_M2;
				ST_M2:  state_q <= ST_FIN;
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				pos_q <= in_pos;
				res_q <= dflt_q;
			end
			ST_SCAN: begin
				if (cmp_vld_q && cmp_le) begin
					t1_q  <= rd_time;
					v1_q  <= rd_value;
					sh1_q <= rd_shape;
				end
				if (cmp_vld_q && cmp_ge && !have_a_q) begin
					t2_q <= rd_time;
					v2_q <= rd_value;
				end
				if (scan_done) begin
					res_q <= have_b_q ? v1_q : v2_q;
				end
			end
			ST_NUM: r_q   <= sub_diff[TIME_BITS-1:0];
			ST_DEN: den_q <= sub_diff[TIME_BITS-1:0];
			ST_DIV: begin
				// restoring step: 2r - den when it does not borrow
				if (!sub_flags.borrow) begin
					r_q <= sub_diff[TIME_BITS-1:0];
					q_q <= {q_q[FW-2:0], 1'b1};
				end else begin
					r_q <= {r_q[TIME_BITS-2:0], 1'b0};
					q_q <= {q_q[FW-2:0], 1'b0};
				end
			end
			ST_SQ:  prod_q <= mul_prod;
			ST_SHP: s_q    <= s_nx;
			ST_M1:  prod_q <= mul_prod;
			ST_M2: begin
				acc_q  <= prod_q;
				prod_q <= mul_prod;
			end
			ST_FIN: res_q <= blend_sum[16 +: VW];
			ST_OUT: begin
				if (out_free) begin
					m_data_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_data_q;

	`BEE_ASSERT_IMP(a_cmp_only_in_scan, clk, arst_n, cmp_vld_q, state_q == ST_SCAN)
	`BEE_ASSERT_IMP(a_div_rem_below_den, clk, arst_n, state_q == ST_DIV, r_q < den_q)
	`BEE_ASSERT_IMP(a_num_has_bracket, clk, arst_n, state_q == ST_NUM, have_b_q && have_a_q && !b_eq_q && !a_eq_q)
	`BEE_ASSERT_IMP(a_result_unity_max, clk, arst_n, m_tvalid_q, m_data_q <= bee_pkg::UNITY)
	`BEE_ASSERT_NXT(a_eval_starts_scan, clk, arst_n, eval_acc && (cnt_q != '0), state_q == ST_SCAN)

endmodule

[verif/breakpoint_envelope_evaluator_core_tb.sv]
module breakpoint_envelope_evaluator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH  = 64;
	localparam int DRAIN_CYCLES = 100;
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_WORDS = 1150;

	// register indexes the core does not decode
	localparam logic [bee_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [bee_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// shape codes that fall back to linear
	localparam logic [bee_pkg::SHAPE_W-1:0] SHAPE_SPARE_5 = 3'd5;
	localparam logic [bee_pkg::SHAPE_W-1:0] SHAPE_SPARE_6 = 3'd6;
	localparam logic [bee_pkg::SHAPE_W-1:0] SHAPE_SPARE_7 = 3'd7;

	localparam logic [bee_pkg::TIME_W-1:0] TIME_MAX = '1;

	typedef enum {RX_OPEN, RX_CHOPPY, RX_STALLS} rx_pattern_t;
	typedef enum {TAB_SORTED, TAB_REPEATS, TAB_SCRAMBLED} table_style_t;

	// Breakpoint table copy, register copy and queue of pending curve values
	class envelope_curve_model;
		logic [bee_pkg::TIME_W-1:0]  time_tab [TABLE_DEPTH];
		logic [bee_pkg::VALUE_W-1:0] value_tab [TABLE_DEPTH];
		logic [bee_pkg::SHAPE_W-1:0] shape_tab [TABLE_DEPTH];
		int                          point_total;
		logic [bee_pkg::VALUE_W-1:0] empty_value;
		logic [bee_pkg::VALUE_W-1:0] pending_curve_values [$];

		function new();
			point_total = 0;
			empty_value = bee_pkg::UNITY;
			foreach (time_tab[i]) begin
				time_tab[i]  = '0;
				value_tab[i] = '0;
				shape_tab[i] = bee_pkg::SHAPE_STEP;
			end
		endfunction

		function logic [bee_pkg::VALUE_W-1:0] clip_unity(logic [bee_pkg::VALUE_W-1:0] v);
			return (v > bee_pkg::UNITY) ? bee_pkg::UNITY : v;
		endfunction

		function void note_register(logic [bee_pkg::CFG_IDX_W-1:0] idx,
				logic [bee_pkg::CFG_DATA_W-1:0] data);
			if (idx == bee_pkg::REG_POINT_COUNT) begin
				point_total = (data[bee_pkg::COUNT_W-1:0] > TABLE_DEPTH) ? TABLE_DEPTH
					: int'(data[bee_pkg::COUNT_W-1:0]);
			end else if (idx == bee_pkg::REG_EMPTY_DEFAULT) begin
				empty_value = clip_unity(data);
			end
		endfunction

		// curve value at a sample position
		function logic [bee_pkg::VALUE_W-1:0] curve_at(logic [bee_pkg::TIME_W-1:0] pos);
			int i;
			int lo_i;
			int hi_i;
			logic [63:0] den, rem, gap, tt, u, s, v1, v2, mix;
			logic [bee_pkg::FRAC_W-1:0] q;
			lo_i = -1;
			hi_i = -1;
			if (point_total == 0)
				return empty_value;
			for (i = point_total - 1; i >= 0; i--) begin
				if (time_tab[i] <= pos) begin
					lo_i = i;
					break;
				end
			end
			for (i = 0; i < point_total; i++) begin
				if (time_tab[i] >= pos) begin
					hi_i = i;
					break;
				end
			end
			if (lo_i >= 0 && hi_i >= 0) begin
				if (time_tab[lo_i] == pos)
					return value_tab[lo_i];
				if (time_tab[hi_i] > pos) begin
					if (shape_tab[lo_i] == bee_pkg::SHAPE_STEP)
						return value_tab[lo_i];
					// restoring divide: q = floor(rem * 2^16 / den)
					den = 64'(time_tab[hi_i]) - 64'(time_tab[lo_i]);
					rem = 64'(pos) - 64'(time_tab[lo_i]);
					q = '0;
					repeat (bee_pkg::FRAC_W) begin
						gap = den - rem;
						q = q << 1;
						if (rem >= gap) begin
							rem = rem - gap;
							q[0] = 1'b1;
						end else begin
							rem = rem + rem;
						end
					end
					tt = 64'(q);
					u = 64'd65536 - tt;
					case (shape_tab[lo_i])
						bee_pkg::SHAPE_EASE_IN: s = (tt * tt + 64'd32768) >> 16;
						bee_pkg::SHAPE_EASE_OUT: s = 64'd65536 - ((u * u + 64'd32768) >> 16);
						bee_pkg::SHAPE_S_CURVE: begin
							if (tt < 64'd32768)
								s = (tt * tt + 64'd16384) >> 15;
							else
								s = 64'd65536 - ((u * u + 64'd16384) >> 15);
						end
						default: s = tt;
					endcase
					v1 = 64'(value_tab[lo_i]);
					v2 = 64'(value_tab[hi_i]);
					mix = (v1 * (64'd65536 - s) + v2 * s + 64'd32768) >> 16;
					return mix[bee_pkg::VALUE_W-1:0];
				end
			end
			if (lo_i >= 0)
				return value_tab[lo_i];
			if (hi_i >= 0)
				return value_tab[hi_i];
			return empty_value;
		endfunction

		function void note_word(logic mode, logic [bee_pkg::IN_DATA_W-1:0] data);
			logic [bee_pkg::IDX_W-1:0] slot;
			slot = data[bee_pkg::IDX_LSB +: bee_pkg::IDX_W];
			if (mode == bee_pkg::MODE_WRITE) begin
				time_tab[slot]  = data[bee_pkg::TIME_LSB +: bee_pkg::TIME_W];
				value_tab[slot] = clip_unity(data[bee_pkg::VALUE_LSB +: bee_pkg::VALUE_W]);
				shape_tab[slot] = data[bee_pkg::SHAPE_LSB +: bee_pkg::SHAPE_W];
			end else begin
				pending_curve_values.insert(pending_curve_values.size(),
					curve_at(data[bee_pkg::POS_LSB +: bee_pkg::TIME_W]));
			end
		endfunction

		function bit check_result(logic [bee_pkg::VALUE_W-1:0] got, output string why);
			logic [bee_pkg::VALUE_W-1:0] want;
			why = "";
			if (pending_curve_values.size() == 0) begin
				why = $sformatf("curve_value %0d with no evaluate word pending", got);
				return 1'b0;
			end
			want = pending_curve_values.pop_front();
			if (got !== want) begin
				why = $sformatf("curve_value %0d, expected %0d", got, want);
				return 1'b0;
			end
			return 1'b1;
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [bee_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bee_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [bee_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic                           s_axis_tuser;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [bee_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	envelope_curve_model model = new();

	int err_count = 0;
	int words_sent = 0;
	int burst_left = 0;
	int gap_max = 0;
	int idle_cycles = 0;
	logic [bee_pkg::TIME_W-1:0]     plan_time [TABLE_DEPTH];
	logic [bee_pkg::CFG_IDX_W-1:0]  reg_idx_q [$];
	logic [bee_pkg::CFG_DATA_W-1:0] reg_data_q [$];

	breakpoint_envelope_evaluator_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: open stretches, choppy ready, long stalls
	initial begin
		rx_pattern_t rx_mode;
		int hold_left;
		logic level;
		rx_mode = RX_OPEN;
		hold_left = 0;
		level = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0) begin
				if ($urandom_range(0, 15) == 0)
					rx_mode = rx_pattern_t'($urandom_range(0, 2));
				case (rx_mode)
					RX_OPEN: begin
						level = 1'b1;
						hold_left = 40;
					end
					RX_CHOPPY: begin
						level = 1'($urandom_range(0, 1));
						hold_left = $urandom_range(1, 3);
					end
					default: begin
						level = !level;
						hold_left = level ? $urandom_range(1, 4) : $urandom_range(1, 30);
					end
				endcase
			end
			hold_left--;
			m_axis_tready <= level;
		end
	end

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		err_count++;
	endtask

	// word monitor: config, results, then accepted input words
	always @(posedge clk) begin
		string why;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				model.note_register(cfg_index, cfg_data);
			if (m_axis_tvalid && m_axis_tready) begin
				if (!model.check_result(m_axis_tdata, why))
					report(why);
			end
			if (s_axis_tvalid && s_axis_tready)
				model.note_word(s_axis_tuser, s_axis_tdata);
		end
	end

	// watchdog on cycles with no word moving anywhere
	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("breakpoint_envelope_evaluator_core_tb failed");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [bee_pkg::TIME_W-1:0] rand_time();
		logic [63:0] r;
		r = rand64();
		return r[bee_pkg::TIME_W-1:0];
	endfunction

	// mostly in range, with the ends and some above unity
	function automatic logic [bee_pkg::VALUE_W-1:0] rand_value();
		logic [31:0] r;
		case ($urandom_range(0, 7))
			0: r = 0;
			1: r = bee_pkg::UNITY;
			2: r = $urandom;
			default: r = $urandom_range(0, bee_pkg::UNITY);
		endcase
		return r[bee_pkg::VALUE_W-1:0];
	endfunction

	// one input word; the sender runs in bursts with random gaps
	task automatic send_word(input logic mode, input logic [bee_pkg::IDX_W-1:0] slot,
			input logic [bee_pkg::TIME_W-1:0] t, input logic [bee_pkg::VALUE_W-1:0] v,
			input logic [bee_pkg::SHAPE_W-1:0] shp, input logic [bee_pkg::TIME_W-1:0] pos);
		logic [bee_pkg::IN_DATA_W-1:0] data;
		int gap;
		data = '0;
		data[bee_pkg::IDX_LSB +: bee_pkg::IDX_W]     = slot;
		data[bee_pkg::TIME_LSB +: bee_pkg::TIME_W]   = t;
		data[bee_pkg::VALUE_LSB +: bee_pkg::VALUE_W] = v;
		data[bee_pkg::SHAPE_LSB +: bee_pkg::SHAPE_W] = shp;
		data[bee_pkg::POS_LSB +: bee_pkg::TIME_W]    = pos;
		if (burst_left == 0) begin
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= mode;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
		words_sent++;
	endtask

	task automatic send_point(input int slot, input logic [bee_pkg::TIME_W-1:0] t,
			input logic [bee_pkg::VALUE_W-1:0] v, input logic [bee_pkg::SHAPE_W-1:0] shp);
		send_word(bee_pkg::MODE_WRITE, slot[bee_pkg::IDX_W-1:0], t, v, shp, rand_time());
	endtask

	// unused write fields carry random bits
	task automatic send_eval(input logic [bee_pkg::TIME_W-1:0] pos);
		logic [31:0] r;
		r = $urandom;
		send_word(bee_pkg::MODE_EVAL, r[bee_pkg::IDX_W-1:0], rand_time(), rand_value(),
			r[10:8], pos);
	endtask

	// hold the sender until every curve value is back, then wait extra cycles
	task automatic drain_results(input int extra);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (model.pending_curve_values.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic queue_reg(input logic [bee_pkg::CFG_IDX_W-1:0] idx,
			input logic [bee_pkg::CFG_DATA_W-1:0] data);
		reg_idx_q.insert(reg_idx_q.size(), idx);
		reg_data_q.insert(reg_data_q.size(), data);
	endtask

	// register writes back to back, valid dropped after the last one
	task automatic flush_regs();
		while (reg_idx_q.size() != 0) begin
			cfg_valid <= 1'b1;
			cfg_index <= reg_idx_q.pop_front();
			cfg_data  <= reg_data_q.pop_front();
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		table_style_t style;
		logic [63:0] spacing, step, span;
		logic [bee_pkg::TIME_W-1:0] t, pos;
		logic [bee_pkg::CFG_DATA_W-1:0] count_word;
		logic [31:0] r;
		int n, k, lo, slot, i, random_start;

		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = bee_pkg::REG_POINT_COUNT;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = bee_pkg::MODE_WRITE;
		foreach (plan_time[j])
			plan_time[j] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table returns the default, unity after reset
		gap_max = 3;
		send_eval('0);
		send_eval(TIME_MAX);
		drain_results(DRAIN_CYCLES);
		// default above unity saturates
		queue_reg(bee_pkg::REG_EMPTY_DEFAULT, 16'hFFFF);
		flush_regs();
		send_eval(rand_time());
		drain_results(DRAIN_CYCLES);
		// undecoded indexes are ignored, count keeps only its low bits
		queue_reg(bee_pkg::REG_EMPTY_DEFAULT, 16'h0000);
		queue_reg(REG_SPARE_A, 16'hFFFF);
		queue_reg(REG_SPARE_B, 16'hFFFF);
		queue_reg(bee_pkg::REG_POINT_COUNT, 16'hFF80);
		flush_regs();
		send_eval(rand_time());
		send_eval(TIME_MAX);

		// one segment per shape, last point at the top of the time range
		send_point(0, 48'd100, 16'd0, bee_pkg::SHAPE_LINEAR);
		send_point(1, 48'd200, bee_pkg::UNITY, bee_pkg::SHAPE_EASE_IN);
		send_point(2, 48'd300, 16'd0, bee_pkg::SHAPE_EASE_OUT);
		send_point(3, 48'd400, 16'hFFFF, bee_pkg::SHAPE_S_CURVE);
		send_point(4, 48'd500, 16'd1000, bee_pkg::SHAPE_STEP);
		send_point(5, 48'd600, 16'd20000, SHAPE_SPARE_5);
		send_point(6, 48'd700, 16'd5, SHAPE_SPARE_6);
		send_point(7, TIME_MAX, 16'd0, SHAPE_SPARE_7);
		drain_results(DRAIN_CYCLES);
		queue_reg(bee_pkg::REG_POINT_COUNT, 16'd8);
		queue_reg(bee_pkg::REG_EMPTY_DEFAULT, 16'd12345);
		flush_regs();
		// before the first point, exact hits, each segment and the last point
		send_eval(48'd0);
		send_eval(48'd100);
		send_eval(48'd150);
		send_eval(48'd250);
		send_eval(48'd350);
		send_eval(48'd410);
		send_eval(48'd490);
		send_eval(48'd550);
		send_eval(48'd650);
		send_eval(48'd750);
		send_eval(48'h8000_0000_0000);
		send_eval(TIME_MAX);

		// random phases: new table and registers at idle, then evaluate words
		random_start = words_sent;
		while (words_sent - random_start < RANDOM_WORDS) begin
			drain_results(DRAIN_CYCLES);
			case ($urandom_range(0, 15))
				0: n = 0;
				1, 2: n = TABLE_DEPTH;
				3, 4, 5: n = $urandom_range(9, 32);
				default: n = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 4))
				3: style = TAB_REPEATS;
				4: style = TAB_SCRAMBLED;
				default: style = TAB_SORTED;
			endcase
			gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);

			// count above the table depth saturates; all slots are written then
			count_word = bee_pkg::CFG_DATA_W'(n);
			if (n == TABLE_DEPTH && $urandom_range(0, 1) == 1)
				count_word = bee_pkg::CFG_DATA_W'($urandom_range(TABLE_DEPTH, 127));
			if ($urandom_range(0, 3) == 0) begin
				r = $urandom;
				count_word[bee_pkg::CFG_DATA_W-1:bee_pkg::COUNT_W] =
					r[bee_pkg::CFG_DATA_W-bee_pkg::COUNT_W-1:0];
			end
			queue_reg(bee_pkg::REG_POINT_COUNT, count_word);
			if ($urandom_range(0, 2) == 0)
				queue_reg(bee_pkg::REG_EMPTY_DEFAULT, rand_value());
			flush_regs();

			// table slots 0..n-1 are written before any evaluate word
			case ($urandom_range(0, 3))
				0: spacing = 64'd4;
				1: spacing = 64'd1000;
				2: spacing = 64'd1 << 20;
				default: spacing = 64'd1 << 40;
			endcase
			t = rand_time() >> 1;
			for (i = 0; i < n; i++) begin
				step = (rand64() % spacing) + 64'd1;
				case (style)
					TAB_SORTED: t = t + step[bee_pkg::TIME_W-1:0];
					TAB_REPEATS: begin
						if ($urandom_range(0, 2) != 0)
							t = t + step[bee_pkg::TIME_W-1:0];
					end
					default: begin
						if ($urandom_range(0, 1) == 1)
							t = rand_time();
						else
							t = bee_pkg::TIME_W'($urandom_range(0, 64));
					end
				endcase
				plan_time[i] = t;
				r = $urandom;
				send_point(i, t, rand_value(), r[bee_pkg::SHAPE_W-1:0]);
			end

			k = $urandom_range(4, 24);
			repeat (k) begin
				// stray point write, sometimes into the live table
				if ($urandom_range(0, 11) == 0) begin
					slot = $urandom_range(0, TABLE_DEPTH - 1);
					t = rand_time();
					if (slot < n)
						plan_time[slot] = t;
					r = $urandom;
					send_point(slot, t, rand_value(), r[bee_pkg::SHAPE_W-1:0]);
				end
				if ($urandom_range(0, 39) == 0)
					drain_results(0);
				lo = (n > 1) ? $urandom_range(0, n - 2) : 0;
				case ($urandom_range(0, 9))
					0: pos = rand_time();
					1: begin
						if (n > 0)
							pos = plan_time[$urandom_range(0, n - 1)];
						else
							pos = TIME_MAX;
					end
					2: pos = plan_time[0] - bee_pkg::TIME_W'($urandom_range(0, 3));
					3: begin
						if (n > 0 && $urandom_range(0, 1) == 1)
							pos = plan_time[n - 1] + bee_pkg::TIME_W'($urandom_range(0, 3));
						else
							pos = TIME_MAX;
					end
					default: begin
						if (n > 1 && plan_time[lo + 1] > plan_time[lo]) begin
							span = 64'(plan_time[lo + 1]) - 64'(plan_time[lo]) + 64'd1;
							step = rand64() % span;
							pos = plan_time[lo] + step[bee_pkg::TIME_W-1:0];
						end else begin
							pos = rand_time();
						end
					end
				endcase
				send_eval(pos);
			end
		end

		drain_results(DRAIN_CYCLES);
		if (model.pending_curve_values.size() != 0)
			report($sformatf("%0d curve values never arrived",
				model.pending_curve_values.size()));
		if (err_count == 0)
			$display("breakpoint_envelope_evaluator_core_tb passed");
		else
			$display("breakpoint_envelope_evaluator_core_tb failed");
		$finish;
	end

endmodule
